@@ rtl/uitfr_pkg.sv @@
// shared types and constants for the uart idle-timeout frame receiver
package uitfr_pkg;

  localparam int unsigned BUF_DEPTH_DEF    = 256;
  localparam int unsigned TIMEOUT_W        = 16;
  localparam int unsigned BYTE_W           = 8;
  localparam logic [TIMEOUT_W-1:0] IDLE_TIMEOUT_RST = 16'd100;

  typedef enum logic [1:0] {
    REQ_BYTE    = 2'd0,
    REQ_TICK    = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_READ    = 2'd3
  } req_t;

  // result of one item before the store read data joins it
  typedef struct packed {
    logic              frame_done;
    logic [BYTE_W-1:0] frame_length;
    logic              read_valid;
    logic              rd_pending;
  } res_t;

endpackage

@@ rtl/uitfr_in_if.sv @@
// request channel: valid/ready with a byte, tick, restart or read request
interface uitfr_in_if;
  import uitfr_pkg::*;

  logic              valid;
  logic              ready;
  req_t              req_type;
  logic [BYTE_W-1:0] rx_byte;
  logic [BYTE_W-1:0] read_index;

  modport source (output valid, output req_type, output rx_byte, output read_index,
                  input ready);
  modport sink   (input valid, input req_type, input rx_byte, input read_index,
                  output ready);
endinterface

// result channel: valid/ready with frame status and read data
interface uitfr_out_if;
  import uitfr_pkg::*;

  logic              valid;
  logic              ready;
  logic              frame_done;
  logic [BYTE_W-1:0] frame_length;
  logic              read_valid;
  logic [BYTE_W-1:0] read_data;

  modport source (output valid, output frame_done, output frame_length,
                  output read_valid, output read_data, input ready);
  modport sink   (input valid, input frame_done, input frame_length,
                  input read_valid, input read_data, output ready);
endinterface

@@ rtl/uart_idle_timeout_frame_receiver_core.sv @@
// top level of the uart idle-timeout frame receiver
//
// in_ch carries one request per transfer: a received byte, an idle-timer tick,
// a restart of reception, or a read of one buffered byte by index.
// out_ch returns exactly one result per request: the done flag, the frame
// length (0 while not done), and for reads the valid flag and the byte.
// cfg_wr_en/cfg_wr_data set the idle timeout in ticks; write only while idle.
// A request is applied to the frame state in the cycle it is accepted; the
// store is written or read in that cycle and the read data lands in the next,
// joining the result as it moves from the store read stage to the output register.
// Throughput is one request per cycle while the sink takes results: the store
// write or read and the count and timer update all fit in the accept cycle.
// Two result slots (store read stage and output register) let one more
// request in while a result waits; with the sink stalled, in_ch.ready drops
// once both are full and nothing is lost.
// Reset (rst_n low, synchronous) empties the pipeline, clears the count,
// done flag and timer, and loads a timeout of 100; the store is not cleared,
// since only bytes below the count are ever read.
module uart_idle_timeout_frame_receiver_core #(
  parameter int unsigned BUF_DEPTH = uitfr_pkg::BUF_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [uitfr_pkg::TIMEOUT_W-1:0] cfg_wr_data,
  uitfr_in_if.sink                        in_ch,
  uitfr_out_if.source                     out_ch
);
  import uitfr_pkg::*;

  localparam int unsigned AW = $clog2(BUF_DEPTH);

  logic              acc;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_q;
  res_t              res;

  logic              s1_v_r;
  res_t              s1_res_r;
  logic              out_v_r;
  res_t              out_res_r;
  logic [BYTE_W-1:0] out_data_r;
  logic              s1_adv;

  assign s1_adv      = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_adv;
  assign acc         = in_ch.valid && in_ch.ready;

  uitfr_ctrl #(
    .BUF_DEPTH (BUF_DEPTH),
    .AW        (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .acc         (acc),
    .req_type    (in_ch.req_type),
    .rx_byte     (in_ch.rx_byte),
    .read_index  (in_ch.read_index),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .res         (res)
  );

  uitfr_store #(
    .BUF_DEPTH (BUF_DEPTH),
    .AW        (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= acc;
      end
      if (!out_v_r || out_ch.ready) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // store read data is held while stage one waits, since reads only start on accept
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_res_r <= res;
    end
    if (s1_adv) begin
      out_res_r  <= s1_res_r;
      out_data_r <= s1_res_r.rd_pending ? mem_q : '0;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.frame_done   = out_res_r.frame_done;
  assign out_ch.frame_length = out_res_r.frame_length;
  assign out_ch.read_valid   = out_res_r.read_valid;
  assign out_ch.read_data    = out_data_r;

endmodule

@@ rtl/uitfr_store.sv @@
// frame byte store: one write port, one read port with registered data
module uitfr_store #(
  parameter int unsigned BUF_DEPTH = uitfr_pkg::BUF_DEPTH_DEF,
  parameter int unsigned AW        = $clog2(BUF_DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [uitfr_pkg::BYTE_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [uitfr_pkg::BYTE_W-1:0] rdata
);
  import uitfr_pkg::*;

  logic [BYTE_W-1:0] mem [BUF_DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/uitfr_ctrl.sv @@
// frame state: byte count, done flag, idle timer; issues store writes and reads
module uitfr_ctrl #(
  parameter int unsigned BUF_DEPTH = uitfr_pkg::BUF_DEPTH_DEF,
  parameter int unsigned AW        = $clog2(BUF_DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [uitfr_pkg::TIMEOUT_W-1:0] cfg_wr_data,
  input  logic                         acc,
  input  uitfr_pkg::req_t              req_type,
  input  logic [uitfr_pkg::BYTE_W-1:0] rx_byte,
  input  logic [uitfr_pkg::BYTE_W-1:0] read_index,
  output logic                         mem_we,
  output logic [AW-1:0]                mem_waddr,
  output logic [uitfr_pkg::BYTE_W-1:0] mem_wdata,
  output logic                         mem_re,
  output logic [AW-1:0]                mem_raddr,
  output uitfr_pkg::res_t              res
);
  import uitfr_pkg::*;

  localparam int unsigned CMPW = (AW > BYTE_W) ? AW : BYTE_W;
  localparam logic [AW-1:0] LAST_ROOM = AW'(BUF_DEPTH - 1);

  logic [TIMEOUT_W-1:0] timeout_r;
  logic [AW-1:0]        count_r, count_nxt;
  logic                 done_r, done_nxt;
  logic                 run_r, run_nxt;
  logic [TIMEOUT_W-1:0] idle_r, idle_nxt;
  logic [TIMEOUT_W-1:0] idle_inc;
  logic                 rd_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= IDLE_TIMEOUT_RST;
      count_r   <= '0;
      done_r    <= 1'b0;
      run_r     <= 1'b0;
      idle_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      count_r <= count_nxt;
      done_r  <= done_nxt;
      run_r   <= run_nxt;
      idle_r  <= idle_nxt;
    end
  end

  assign idle_inc = idle_r + TIMEOUT_W'(1);
  assign rd_hit   = CMPW'(read_index) < CMPW'(count_r);

  always_comb begin
    count_nxt = count_r;
    done_nxt  = done_r;
    run_nxt   = run_r;
    idle_nxt  = idle_r;
    mem_we    = 1'b0;
    mem_waddr = count_r;
    mem_wdata = rx_byte;
    mem_re    = 1'b0;
    mem_raddr = AW'(read_index);
    if (acc) begin
      unique case (req_type)
        REQ_BYTE: begin
          mem_we = 1'b1;
          if (count_r < LAST_ROOM) begin
            idle_nxt  = '0;
            count_nxt = count_r + AW'(1);
            if (count_r == '0) begin
              run_nxt = 1'b1;
            end
          end else begin
            // count at BUF_DEPTH-1: wrap to the start, timer untouched
            mem_waddr = '0;
            count_nxt = AW'(1);
          end
        end
        REQ_TICK: begin
          if (run_r) begin
            idle_nxt = idle_inc;
            if (idle_inc >= timeout_r) begin
              done_nxt = 1'b1;
              run_nxt  = 1'b0;
              idle_nxt = '0;
            end
          end
        end
        REQ_RESTART: begin
          count_nxt = '0;
          done_nxt  = 1'b0;
        end
        REQ_READ: begin
          mem_re = done_r && rd_hit;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.frame_done   = done_nxt;
    res.frame_length = done_nxt ? BYTE_W'(CMPW'(count_nxt)) : '0;
    res.read_valid   = (req_type == REQ_READ) && done_r;
    res.rd_pending   = mem_re;
  end

endmodule

@@ rtl/uitfr_chk.sv @@
// port-level checks for the frame receiver, bound to the top level
module uitfr_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         frame_done,
  input logic [uitfr_pkg::BYTE_W-1:0] frame_length,
  input logic                         read_valid,
  input logic [uitfr_pkg::BYTE_W-1:0] read_data
);
  import uitfr_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(frame_done) &&
      $stable(frame_length) && $stable(read_valid) && $stable(read_data))
    else $error("result changed while stalled");

  // a valid read is only reported on a closed frame
  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && read_valid |-> frame_done)
    else $error("read valid without frame done");

  // an open frame reports no length
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !frame_done |-> frame_length == '0)
    else $error("length reported on open frame");

  // no data on an invalid read
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !read_valid |-> read_data == '0)
    else $error("read data on invalid read");

endmodule

bind uart_idle_timeout_frame_receiver_core uitfr_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .frame_done   (out_ch.frame_done),
  .frame_length (out_ch.frame_length),
  .read_valid   (out_ch.read_valid),
  .read_data    (out_ch.read_data)
);

@@ sim/tb_top.sv @@
// testbench for the uart idle-timeout frame receiver: random frames checked against a predictor
module tb_top;
  import uitfr_pkg::*;

  localparam int unsigned GAP_MAX     = 9;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned REPORT_MAX  = 100;

  typedef struct packed {
    req_t              kind;
    logic [BYTE_W-1:0] rx_byte;
    logic [BYTE_W-1:0] read_index;
  } request_t;

  typedef struct packed {
    logic              frame_done;
    logic [BYTE_W-1:0] frame_length;
    logic              read_valid;
    logic [BYTE_W-1:0] read_data;
  } frame_status_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [TIMEOUT_W-1:0] cfg_wr_data;

  uitfr_in_if  in_ch ();
  uitfr_out_if out_ch ();

  uart_idle_timeout_frame_receiver_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // predicted frame state
  logic [BYTE_W-1:0]    frame_bytes [BUF_DEPTH_DEF];
  int unsigned          fill_count;
  bit                   frame_closed;
  bit                   timer_on;
  logic [TIMEOUT_W-1:0] idle_ticks;
  logic [TIMEOUT_W-1:0] timeout_ticks;

  request_t      pending_reqs [$];
  frame_status_t expected_status [$];

  int unsigned in_wait;
  int unsigned out_wait;
  bit          no_gaps;
  int unsigned err_count;
  int unsigned stuck_cycles;
  int unsigned queued;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int unsigned draw_wait();
    return no_gaps ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic frame_status_t predict_frame_status(request_t r);
    frame_status_t res;
    res = '0;
    case (r.kind)
      REQ_BYTE: begin
        if (fill_count < BUF_DEPTH_DEF - 1) begin
          idle_ticks = '0;
          if (fill_count == 0) timer_on = 1'b1;
          frame_bytes[fill_count[BYTE_W-1:0]] = r.rx_byte;
          fill_count++;
        end else begin
          // fill count at BUF_DEPTH-1 wraps to the start, timer untouched
          frame_bytes[0] = r.rx_byte;
          fill_count = 1;
        end
      end
      REQ_TICK: begin
        if (timer_on) begin
          idle_ticks = idle_ticks + 1'b1;
          if (idle_ticks >= timeout_ticks) begin
            frame_closed = 1'b1;
            timer_on = 1'b0;
            idle_ticks = '0;
          end
        end
      end
      REQ_RESTART: begin
        fill_count = 0;
        frame_closed = 1'b0;
      end
      default: begin
        if (frame_closed) begin
          res.read_valid = 1'b1;
          if (r.read_index < fill_count) res.read_data = frame_bytes[r.read_index];
        end
      end
    endcase
    res.frame_done   = frame_closed;
    res.frame_length = frame_closed ? fill_count[BYTE_W-1:0] : '0;
    return res;
  endfunction

  function automatic void queue_request(req_t kind, logic [BYTE_W-1:0] b,
                                        logic [BYTE_W-1:0] idx);
    request_t r;
    r.kind = kind;
    r.rx_byte = b;
    r.read_index = idx;
    pending_reqs.push_back(r);
    queued++;
  endfunction

  function automatic void queue_noise();
    queue_request(req_t'($urandom_range(0, 3)), rand_byte(), rand_byte());
  endfunction

  // one frame: optional restart, bytes with stray ticks and noise, idle ticks, reads, maybe noise
  function automatic void queue_frame();
    int unsigned pick;
    int unsigned nbytes;
    int unsigned nticks;
    int unsigned nreads;
    int unsigned top_idx;
    if ($urandom_range(0, 3) != 0) queue_request(REQ_RESTART, rand_byte(), rand_byte());
    pick = $urandom_range(0, 99);
    if (pick < 4) nbytes = $urandom_range(250, 262);
    else if (pick < 8) nbytes = 0;
    else nbytes = $urandom_range(1, 12);
    for (int unsigned i = 0; i < nbytes; i++) begin
      queue_request(REQ_BYTE, rand_byte(), rand_byte());
      if ($urandom_range(0, 9) == 0) queue_request(REQ_TICK, rand_byte(), rand_byte());
      if ($urandom_range(0, 19) == 0) queue_noise();
    end
    if (timeout_ticks > 200) nticks = $urandom_range(0, 40);
    else nticks = timeout_ticks - 1 + $urandom_range(0, 3);
    for (int unsigned i = 0; i < nticks; i++)
      queue_request(REQ_TICK, rand_byte(), rand_byte());
    nreads = $urandom_range(1, 6);
    top_idx = (nbytes > 255) ? 255 : nbytes;
    for (int unsigned i = 0; i < nreads; i++) begin
      if ($urandom_range(0, 1) == 0)
        queue_request(REQ_READ, rand_byte(), BYTE_W'($urandom_range(0, top_idx)));
      else
        queue_request(REQ_READ, rand_byte(), rand_byte());
    end
    if ($urandom_range(0, 9) == 0) queue_noise();
  endfunction

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_status.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_timeout(logic [TIMEOUT_W-1:0] value);
    drain();
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    timeout_ticks = value;
  endtask

  task automatic run_frames(int unsigned budget);
    queued = 0;
    while (queued < budget) queue_frame();
    drain();
  endtask

  task automatic report_field(string field, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
    if (want != got) begin
      err_count++;
      if (err_count <= REPORT_MAX)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_wait != 0) begin
      in_wait--;
      in_ch.valid <= 1'b0;
    end else if (pending_reqs.size() != 0) begin
      in_ch.valid      <= 1'b1;
      in_ch.req_type   <= pending_reqs[0].kind;
      in_ch.rx_byte    <= pending_reqs[0].rx_byte;
      in_ch.read_index <= pending_reqs[0].read_index;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // request transfer: predict and queue the expected status
  always @(posedge clk) begin : in_accept
    request_t seen;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen.kind = in_ch.req_type;
      seen.rx_byte = in_ch.rx_byte;
      seen.read_index = in_ch.read_index;
      expected_status.push_back(predict_frame_status(seen));
      void'(pending_reqs.pop_front());
      in_wait = draw_wait();
      // switch now and then between gapped traffic and back-to-back stretches
      if ($urandom_range(0, 63) == 0) no_gaps = !no_gaps;
    end
  end

  // result sink stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_wait != 0) begin
      out_wait--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // result transfer: compare against the oldest expected status
  always @(posedge clk) begin : out_check
    frame_status_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_status.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_MAX)
          $display("%0t: unexpected result, expected none actual done %0d len %0d rv %0d rd %0d",
                   $time, out_ch.frame_done, out_ch.frame_length, out_ch.read_valid,
                   out_ch.read_data);
      end else begin
        want = expected_status.pop_front();
        report_field("frame_done", BYTE_W'(want.frame_done), BYTE_W'(out_ch.frame_done));
        report_field("frame_length", want.frame_length, out_ch.frame_length);
        report_field("read_valid", BYTE_W'(want.read_valid), BYTE_W'(out_ch.read_valid));
        report_field("read_data", want.read_data, out_ch.read_data);
      end
      out_wait = draw_wait();
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_BYTE;
    in_ch.rx_byte = '0;
    in_ch.read_index = '0;
    out_ch.ready = 1'b0;
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
    fill_count = 0;
    frame_closed = 1'b0;
    timer_on = 1'b0;
    idle_ticks = '0;
    timeout_ticks = IDLE_TIMEOUT_RST;
    in_wait = 0;
    out_wait = 0;
    no_gaps = 1'b0;
    err_count = 0;
    stuck_cycles = 0;
    queued = 0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // timeout left at its reset value
    run_frames(250);

    set_timeout(16'd1);
    queue_request(REQ_RESTART, 8'h00, 8'h00);
    queue_request(REQ_READ, 8'h00, 8'h00);      // read while not done
    queue_request(REQ_TICK, 8'hff, 8'hff);      // tick before the first byte
    queue_request(REQ_BYTE, 8'h00, 8'hff);
    queue_request(REQ_BYTE, 8'hff, 8'h00);
    queue_request(REQ_TICK, 8'h00, 8'h00);      // closes the frame
    queue_request(REQ_READ, 8'h00, 8'h00);
    queue_request(REQ_READ, 8'hff, 8'h01);
    queue_request(REQ_READ, 8'h00, 8'h02);      // read at the length
    queue_request(REQ_READ, 8'h00, 8'hff);
    queue_request(REQ_BYTE, 8'h5a, 8'h00);      // appended after done
    queue_request(REQ_READ, 8'h00, 8'h02);
    queue_request(REQ_TICK, 8'h00, 8'h00);      // timer already stopped
    queue_request(REQ_RESTART, 8'hff, 8'hff);
    queue_request(REQ_READ, 8'h00, 8'h00);
    queue_request(REQ_BYTE, 8'ha5, 8'h00);      // first byte restarts the timer
    queue_request(REQ_TICK, 8'h00, 8'h00);
    queue_request(REQ_READ, 8'h00, 8'h00);
    queue_request(REQ_READ, 8'h00, 8'h01);
    drain();
    run_frames(350);

    set_timeout(16'hffff);
    run_frames(120);

    set_timeout(16'($urandom_range(2, 16)));
    run_frames(450);

    set_timeout(16'd7);
    run_frames(400);

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ uart_idle_timeout_frame_receiver_core.f @@
rtl/uitfr_pkg.sv
rtl/uitfr_in_if.sv
rtl/uitfr_store.sv
rtl/uitfr_ctrl.sv
rtl/uart_idle_timeout_frame_receiver_core.sv
rtl/uitfr_chk.sv
sim/tb_top.sv
